/* src/smvs_pkg.sv */
// Shared widths, constants, command codes and control structs for the score statistics block.
package smvs_pkg;

    localparam int MAX_COUNT = 1024;
    localparam int FRAC_BITS = 16;

    localparam int SCORE_W = 7;
    localparam int SQ_W    = 2 * SCORE_W;
    localparam int CNT_W   = 11;
    localparam int SUM_W   = 17;
    localparam int SQS_W   = 24;
    localparam int PA_W    = CNT_W + SQS_W;      // n * sum of squares
    localparam int PB_W    = 2 * SUM_W;          // sum squared
    localparam int NN_W    = 21;                 // n * n, n <= 1024
    localparam int D_W     = 34;                 // n*sumsq - sum^2
    localparam int DVD_W   = D_W + FRAC_BITS;    // widest dividend
    localparam int DVS_W   = NN_W;               // widest divisor
    localparam int ROOT_W  = (D_W + 2 * FRAC_BITS) / 2;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int MEAN_W  = 23;
    localparam int VAR_W   = 28;
    localparam int STD_W   = 22;
    localparam int OUT_W   = CNT_W + MEAN_W + VAR_W + STD_W;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [SCORE_W-1:0] SCORE_TOP = SCORE_W'(100);

    // divider operand / result select
    localparam logic [1:0] DIV_MEAN = 2'd0;
    localparam logic [1:0] DIV_VAR  = 2'd1;
    localparam logic [1:0] DIV_STD  = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       mul;
        logic       sub;
        logic       div_start;
        logic       sqrt_start;
        logic [1:0] div_sel;
        logic       div_store;
        logic       load_out;
    } smvs_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic sqrt_busy;
        logic out_free;
    } smvs_status_t;

endpackage

/* src/smvs_div.sv */
// Restoring divider, one quotient bit per cycle.
module smvs_div
    import smvs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [DVD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DVD_W);

    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W:0]    rem_shift;
    logic              fits;

    assign rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits      = rem_shift >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(DVD_W - 1))
                busy_reg <= 1'b0;
        end
    end

    // quotient bits shift into the dividend register from the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? DVS_W'(rem_shift - {1'b0, dvs_reg}) : DVS_W'(rem_shift);
        end
    end

    assign busy     = busy_reg;
    assign quotient = dvd_reg;

endmodule

/* src/smvs_sqrt.sv */
// Integer square root of d * 2^32, two radicand bits per cycle.
module smvs_sqrt
    import smvs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [D_W-1:0]    radicand,
    output logic              busy,
    output logic [ROOT_W-1:0] root
);

    localparam int STEP_W = $clog2(ROOT_W);
    localparam int REM_W  = ROOT_W + 2;

    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W+1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    logic              fits;

    assign rem_shift = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
    assign trial     = {root_reg, 2'b01};
    assign fits      = rem_shift >= {2'b00, trial};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(ROOT_W - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= {radicand, (RAD_W - D_W)'(0)};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= fits ? REM_W'(rem_shift - {2'b00, trial}) : REM_W'(rem_shift);
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

/* src/smvs_datapath.sv */
// Accumulators, products, divider and root units, and the result register.
module smvs_datapath
    import smvs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  smvs_cmd_t              cmd,
    output smvs_status_t           status,
    input  logic [7:0]             s_tdata,
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_BYTES_W-1:0] m_tdata,
    output logic                   m_tuser
);

    logic [SCORE_W-1:0] score_sat;
    logic [SQ_W-1:0]    score_sq;
    logic               room;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SQS_W-1:0] sqs_reg, sqs_next;
    logic             drop_reg, drop_next;

    logic [CNT_W-1:0] n_reg;
    logic [SUM_W-1:0] s_reg;
    logic [SQS_W-1:0] q_reg;
    logic             dropped_reg;

    logic [PA_W-1:0] pa_reg;
    logic [PB_W-1:0] pb_reg;
    logic [NN_W-1:0] nn_reg;
    logic [D_W-1:0]  d_reg;

    logic [MEAN_W-1:0] mean_reg;
    logic [VAR_W-1:0]  var_reg;
    logic [STD_W-1:0]  std_reg;

    logic [DVD_W-1:0]  dvd;
    logic [DVS_W-1:0]  dvs;
    logic [DVD_W-1:0]  quot;
    logic [ROOT_W-1:0] root;
    logic              div_busy;
    logic              sqrt_busy;

    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;
    logic               out_user_reg;

    assign score_sat = (s_tdata[SCORE_W-1:0] > SCORE_TOP) ? SCORE_TOP : s_tdata[SCORE_W-1:0];
    assign score_sq  = {{SCORE_W{1'b0}}, score_sat} * {{SCORE_W{1'b0}}, score_sat};
    assign room      = count_reg < CNT_W'(MAX_COUNT);

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        sqs_next   = sqs_reg;
        drop_next  = drop_reg;
        if (room)
        begin
            count_next = count_reg + 1'b1;
            sum_next   = sum_reg + SUM_W'(score_sat);
            sqs_next   = sqs_reg + SQS_W'(score_sq);
        end
        else
            drop_next = 1'b1;
    end

    // accumulators clear when the last score of a set is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sqs_reg   <= '0;
            drop_reg  <= 1'b0;
        end
        else if (cmd.accept)
        begin
            if (s_tlast)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                sqs_reg   <= '0;
                drop_reg  <= 1'b0;
            end
            else
            begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
                sqs_reg   <= sqs_next;
                drop_reg  <= drop_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && s_tlast)
        begin
            n_reg       <= count_next;
            s_reg       <= sum_next;
            q_reg       <= sqs_next;
            dropped_reg <= drop_next;
        end
        if (cmd.mul)
        begin
            pa_reg <= {{SQS_W{1'b0}}, n_reg} * {{CNT_W{1'b0}}, q_reg};
            pb_reg <= {{SUM_W{1'b0}}, s_reg} * {{SUM_W{1'b0}}, s_reg};
            nn_reg <= NN_W'({{CNT_W{1'b0}}, n_reg} * {{CNT_W{1'b0}}, n_reg});
        end
        if (cmd.sub)
            d_reg <= D_W'(pa_reg - {1'b0, pb_reg});
        if (cmd.div_store)
        begin
            case (cmd.div_sel)
                DIV_MEAN: mean_reg <= quot[MEAN_W-1:0];
                DIV_VAR:  var_reg  <= quot[VAR_W-1:0];
                DIV_STD:  std_reg  <= quot[STD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cmd.div_sel)
            DIV_MEAN:
            begin
                dvd = DVD_W'({s_reg, {FRAC_BITS{1'b0}}});
                dvs = DVS_W'(n_reg);
            end
            DIV_VAR:
            begin
                dvd = {d_reg, {FRAC_BITS{1'b0}}};
                dvs = nn_reg;
            end
            DIV_STD:
            begin
                dvd = DVD_W'(root);
                dvs = DVS_W'(n_reg);
            end
            default:
            begin
                dvd = '0;
                dvs = DVS_W'(1);
            end
        endcase
    end

    smvs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .busy     (div_busy),
        .quotient (quot)
    );

    smvs_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (d_reg),
        .busy     (sqrt_busy),
        .root     (root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= {std_reg, var_reg, mean_reg, n_reg};
            out_user_reg <= dropped_reg;
        end
    end

    assign status.div_busy  = div_busy;
    assign status.sqrt_busy = sqrt_busy;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_BYTES_W'(out_data_reg);
    assign m_tuser  = out_user_reg;

endmodule

/* src/smvs_ctrl.sv */
// Sequencer: accumulate, form products, run divisions and root, hand off the result.
module smvs_ctrl
    import smvs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tlast,
    output logic         s_tready,
    output smvs_cmd_t    cmd,
    input  smvs_status_t status
);

    localparam logic [3:0] ST_ACC       = 4'd0;
    localparam logic [3:0] ST_MUL       = 4'd1;
    localparam logic [3:0] ST_SUB       = 4'd2;
    localparam logic [3:0] ST_GO_MEAN   = 4'd3;
    localparam logic [3:0] ST_WAIT_MEAN = 4'd4;
    localparam logic [3:0] ST_GO_VAR    = 4'd5;
    localparam logic [3:0] ST_WAIT_VAR  = 4'd6;
    localparam logic [3:0] ST_GO_STD    = 4'd7;
    localparam logic [3:0] ST_WAIT_STD  = 4'd8;
    localparam logic [3:0] ST_OUT       = 4'd9;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_ACC;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.div_sel    = DIV_MEAN;
        s_tready       = 1'b0;
        unique case (state_reg)
            ST_ACC:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && s_tlast)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                cmd.sub    = 1'b1;
                state_next = ST_GO_MEAN;
            end
            ST_GO_MEAN:
            begin
                cmd.div_start  = 1'b1;
                cmd.sqrt_start = 1'b1;
                state_next     = ST_WAIT_MEAN;
            end
            ST_WAIT_MEAN:
            begin
                if (!status.div_busy && !status.sqrt_busy)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = ST_GO_VAR;
                end
            end
            ST_GO_VAR:
            begin
                cmd.div_sel   = DIV_VAR;
                cmd.div_start = 1'b1;
                state_next    = ST_WAIT_VAR;
            end
            ST_WAIT_VAR:
            begin
                cmd.div_sel = DIV_VAR;
                if (!status.div_busy)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = ST_GO_STD;
                end
            end
            ST_GO_STD:
            begin
                cmd.div_sel   = DIV_STD;
                cmd.div_start = 1'b1;
                state_next    = ST_WAIT_STD;
            end
            ST_WAIT_STD:
            begin
                cmd.div_sel = DIV_STD;
                if (!status.div_busy)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // wait here only while the previous result is still unclaimed
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_ACC;
                end
            end
            default:
                state_next = ST_ACC;
        endcase
    end

endmodule

/* src/score_mean_variance_stddev.sv */
// Top level: population mean, variance and standard deviation of a set of scores.
//
//  channel  | direction | sideband | payload
//  ---------+-----------+----------+-------------------------------------------------
//  s_*      | in        | tlast    | score (7 b), tlast ends the set
//  m_*      | out       | tuser    | count, mean, variance, stddev (Q.16), tuser = dropped
//
//  Scores are taken one per cycle while a set accumulates. After the last score s_tready
//  stays low through products and difference, mean division with the root alongside,
//  variance division, stddev division and result load. Each division is a start, 50
//  one-bit steps of the shared divider and a store. A finished result waits in the
//  output register while the next set accumulates; the next result stalls only if that
//  register is still full. Reset clears all sets.
module score_mean_variance_stddev
    import smvs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [6:0] score
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_BYTES_W-1:0] m_tdata,   // [10:0] score_count, [33:11] mean_fixed,
                                              // [61:34] variance_fixed, [83:62] stddev_fixed
    output logic                   m_tuser    // [0] too_many
);

    smvs_cmd_t    cmd;
    smvs_status_t status;

    smvs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    smvs_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* test/tb_top.sv */
// Testbench for score_mean_variance_stddev: score sets driven over the stream ports, statistics checked.
`timescale 1ns / 1ps

module tb_top
    import smvs_pkg::*;
();

    typedef struct {
        logic [CNT_W-1:0]  count;
        logic [MEAN_W-1:0] mean;
        logic [VAR_W-1:0]  var_q;
        logic [STD_W-1:0]  std_q;
        logic              dropped;
    } set_stats_t;

    // floor(sqrt(rad)), two radicand bits per step
    function automatic logic [63:0] int_sqrt(input logic [127:0] rad);
        logic [127:0] rem;
        logic [127:0] trial;
        logic [63:0]  root;
        rem  = '0;
        root = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem   = (rem << 2) | rad[2*i +: 2];
            trial = ({64'b0, root} << 2) | 128'd1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end
            else
            begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    class set_stats_board;
        set_stats_t       stats_q[$];
        longint unsigned  n_scores;
        longint unsigned  sum_acc;
        longint unsigned  sq_acc;
        bit               over_flag;
        int               errors;

        function new();
            n_scores  = 0;
            sum_acc   = 0;
            sq_acc    = 0;
            over_flag = 0;
            errors    = 0;
        endfunction

        function void note_score(logic [SCORE_W-1:0] raw, logic last);
            longint unsigned s;
            longint unsigned n;
            longint unsigned d;
            logic [127:0]    rad;
            set_stats_t      st;
            s = (raw > SCORE_TOP) ? 64'(SCORE_TOP) : 64'(raw);
            if (n_scores < MAX_COUNT)
            begin
                n_scores += 1;
                sum_acc  += s;
                sq_acc   += s * s;
            end
            else
            begin
                over_flag = 1;
            end
            if (!last)
                return;
            n   = n_scores;
            d   = n * sq_acc - sum_acc * sum_acc;
            rad = {64'b0, d} << 32;
            st.count   = CNT_W'(n);
            st.mean    = MEAN_W'((sum_acc << FRAC_BITS) / n);
            st.var_q   = VAR_W'((d << FRAC_BITS) / (n * n));
            st.std_q   = STD_W'(int_sqrt(rad) / n);
            st.dropped = over_flag;
            stats_q.push_back(st);
            n_scores  = 0;
            sum_acc   = 0;
            sq_acc    = 0;
            over_flag = 0;
        endfunction

        function void compare_field(string name, longint unsigned e, longint unsigned a);
            if (e != a)
            begin
                $display("%0t mismatch %s expected %0d actual %0d", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_stats(logic [OUT_BYTES_W-1:0] data, logic user);
            set_stats_t st;
            if (stats_q.size() == 0)
            begin
                $display("%0t mismatch unexpected result expected none actual %h", $time, data);
                errors++;
                return;
            end
            st = stats_q.pop_front();
            compare_field("score_count", st.count, data[10:0]);
            compare_field("mean_fixed", st.mean, data[33:11]);
            compare_field("variance_fixed", st.var_q, data[61:34]);
            compare_field("stddev_fixed", st.std_q, data[83:62]);
            compare_field("too_many", st.dropped, user);
        endfunction

        function int pending();
            return stats_q.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_BYTES_W-1:0] m_tdata;
    logic                   m_tuser;

    set_stats_board board;
    bit             send_idle_mode;
    bit             recv_idle_mode;
    int             results_taken;

    score_mean_variance_stddev DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // mostly in-range scores, some saturating ones, some at the ends
    function automatic logic [SCORE_W-1:0] draw_score();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return SCORE_W'($urandom_range(101, 127));
        else if (r == 1)
            return ($urandom_range(0, 1) == 1) ? SCORE_TOP : '0;
        else
            return SCORE_W'($urandom_range(0, 100));
    endfunction

    // entered and left at a falling edge
    task automatic send_score(input logic [SCORE_W-1:0] sc, input logic last);
        int gap;
        if ($urandom_range(0, 63) == 0)
            send_idle_mode = !send_idle_mode;
        gap = send_idle_mode ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = {1'b0, sc};
        s_tlast  = last;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_score(sc, last);
        @(negedge clk);
    endtask

    task automatic send_set(input int len);
        for (int k = 0; k < len; k++)
            send_score(draw_score(), k == len - 1);
    endtask

    // result side: random hold-offs, one long one to back the block up
    initial
    begin
        int gap;
        m_tready      = 1'b0;
        results_taken = 0;
        recv_idle_mode = 1'b1;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                recv_idle_mode = !recv_idle_mode;
            gap = recv_idle_mode ? $urandom_range(0, 16) : 0;
            if (results_taken == 12)
                gap = 600;
            if (gap > 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            board.check_stats(m_tdata, m_tuser);
            results_taken++;
            @(negedge clk);
        end
    end

    initial
    begin
        int sent;
        int len;
        board          = new();
        send_idle_mode = 1'b1;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        rst_n          = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // single-score and short sets at the ends, saturation, walking ones
        send_score(7'd0, 1'b1);
        send_score(7'd100, 1'b1);
        send_score(7'd127, 1'b1);
        send_score(7'd0, 1'b0);
        send_score(7'd100, 1'b1);
        send_score(7'd127, 1'b0);
        send_score(7'd0, 1'b0);
        send_score(7'd50, 1'b0);
        send_score(7'd101, 1'b1);
        for (int b = 0; b < SCORE_W; b++)
            send_score(SCORE_W'(1 << b), b == SCORE_W - 1);

        // full set with widest spread, then an overlong tail that is dropped;
        // the dropped last score still closes the set
        for (int k = 0; k < MAX_COUNT + 6; k++)
        begin
            if (k < MAX_COUNT)
                send_score((k % 2 == 1) ? SCORE_TOP : 7'd0, 1'b0);
            else
                send_score(7'd127, k == MAX_COUNT + 5);
        end

        sent = 0;
        while (sent < 360)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            send_set(len);
            sent += len;
        end
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* files.f */
src/smvs_pkg.sv
src/smvs_div.sv
src/smvs_sqrt.sv
src/smvs_datapath.sv
src/smvs_ctrl.sv
src/score_mean_variance_stddev.sv
test/tb_top.sv
